@@ hw/rtl/ucs2u8_pkg.sv @@
// Shared types and constants for the UCS-2 to UTF-8 stream encoder.
`default_nettype none

package ucs2u8_pkg;

  localparam int unsigned CfgWidth   = 24;
  localparam int unsigned UnitWidth  = 16;
  localparam int unsigned ByteWidth  = 8;
  localparam int unsigned QDepth     = 4;
  localparam int unsigned QPtrWidth  = 2;
  localparam int unsigned QCntWidth  = 3;

  localparam logic [CfgWidth-1:0] BufSizeReset = 24'd256;

  localparam logic [7:0] LeadTwo   = 8'hC0;
  localparam logic [7:0] LeadThree = 8'hE0;
  localparam logic [7:0] ContByte  = 8'h80;

  localparam logic [1:0] NumOne   = 2'd1;
  localparam logic [1:0] NumTwo   = 2'd2;
  localparam logic [1:0] NumThree = 2'd3;

  localparam logic [1:0] IdxFirst  = 2'd0;
  localparam logic [1:0] IdxSecond = 2'd1;
  localparam logic [1:0] IdxThird  = 2'd2;

  typedef struct packed {
    logic [ByteWidth-1:0] byte0;
    logic [ByteWidth-1:0] byte1;
    logic [ByteWidth-1:0] byte2;
    logic [1:0]           num_bytes;
    logic                 store;
    logic                 summary;
    logic [CfgWidth-1:0]  length;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } push_t;

  typedef struct packed {
    logic   full;
    logic   empty;
    entry_t head;
  } qstat_t;

endpackage

`default_nettype wire

@@ hw/rtl/ucs2u8_front.sv @@
// Front end: accepts code units, classifies them, keeps the running length.
`default_nettype none

module ucs2u8_front
  import ucs2u8_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = 24
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_valid_i,
  input  wire logic [CfgWidth-1:0]  cfg_buffer_size_i,
  input  wire logic                 in_valid_i,
  input  wire logic [UnitWidth-1:0] code_unit_i,
  input  wire logic                 end_marker_i,
  input  wire logic                 q_full_i,
  output push_t                     push_o
);

  localparam int unsigned LenW1 = LENGTH_BITS + 1;
  localparam int unsigned CmpW  = ((LENGTH_BITS > CfgWidth) ? LENGTH_BITS : CfgWidth) + 1;

  logic [CfgWidth-1:0]    buf_size_q;
  logic [LENGTH_BITS-1:0] run_len_q, run_len_d;
  logic [1:0]             num;
  logic [ByteWidth-1:0]   b0, b1, b2;
  logic [CmpW-1:0]        len_ext, need_ext, size_ext;
  logic [LenW1-1:0]       len_sum;
  logic                   fits;
  logic                   accept;

  always_comb begin
    if (code_unit_i[15:7] == 9'd0) begin
      num = NumOne;
      b0  = code_unit_i[7:0];
      b1  = '0;
      b2  = '0;
    end else if (code_unit_i[15:11] == 5'd0) begin
      num = NumTwo;
      b0  = LeadTwo | {3'd0, code_unit_i[10:6]};
      b1  = ContByte | {2'd0, code_unit_i[5:0]};
      b2  = '0;
    end else begin
      num = NumThree;
      b0  = LeadThree | {4'd0, code_unit_i[15:12]};
      b1  = ContByte | {2'd0, code_unit_i[11:6]};
      b2  = ContByte | {2'd0, code_unit_i[5:0]};
    end
  end

  assign len_ext  = CmpW'(run_len_q);
  assign size_ext = CmpW'(buf_size_q);
  assign need_ext = len_ext + CmpW'(num) + CmpW'(1);
  assign fits     = need_ext < size_ext;
  assign len_sum  = LenW1'(run_len_q) + LenW1'(num);
  assign accept   = in_valid_i && !q_full_i;

  always_comb begin
    run_len_d = run_len_q;
    if (accept) begin
      if (end_marker_i) begin
        run_len_d = '0;
      end else if (len_sum[LENGTH_BITS]) begin
        run_len_d = '1;
      end else begin
        run_len_d = len_sum[LENGTH_BITS-1:0];
      end
    end
  end

  always_comb begin
    push_o.valid = accept && (end_marker_i || fits);
    if (end_marker_i) begin
      push_o.entry.byte0     = '0;
      push_o.entry.byte1     = '0;
      push_o.entry.byte2     = '0;
      push_o.entry.num_bytes = NumOne;
      push_o.entry.store     = buf_size_q != '0;
      push_o.entry.summary   = 1'b1;
      push_o.entry.length    = len_ext[CfgWidth-1:0];
    end else begin
      push_o.entry.byte0     = b0;
      push_o.entry.byte1     = b1;
      push_o.entry.byte2     = b2;
      push_o.entry.num_bytes = num;
      push_o.entry.store     = 1'b1;
      push_o.entry.summary   = 1'b0;
      push_o.entry.length    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_size_q <= BufSizeReset;
      run_len_q  <= '0;
    end else begin
      if (cfg_valid_i) begin
        buf_size_q <= cfg_buffer_size_i;
      end
      run_len_q <= run_len_d;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/ucs2u8_queue.sv @@
// Short request queue between the front end and the byte emitter.
`default_nettype none

module ucs2u8_queue
  import ucs2u8_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  push_t     push_i,
  input  wire logic pop_i,
  output qstat_t    stat_o
);

  entry_t               mem_q [QDepth];
  logic [QPtrWidth-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntWidth-1:0] count_q, count_d;
  logic                 do_push, do_pop;

  assign stat_o.full  = count_q == QCntWidth'(QDepth);
  assign stat_o.empty = count_q == '0;
  assign stat_o.head  = mem_q[rd_ptr_q];

  assign do_push = push_i.valid && !stat_o.full;
  assign do_pop  = pop_i && !stat_o.empty;

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + QCntWidth'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - QCntWidth'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QPtrWidth'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPtrWidth'(1);
      end
      count_q <= count_d;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/ucs2u8_back.sv @@
// Back end: walks queued requests and emits one byte per cycle while the output is not stalled and a request is queued.
`default_nettype none

module ucs2u8_back
  import ucs2u8_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  qstat_t                    q_stat_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [ByteWidth-1:0]      out_byte_o,
  output logic                      store_byte_o,
  output logic                      is_summary_o,
  output logic [CfgWidth-1:0]       encoded_length_o,
  output logic                      last_o
);

  logic                 valid_q;
  logic [ByteWidth-1:0] byte_q;
  logic                 store_q, summary_q, last_q;
  logic [CfgWidth-1:0]  length_q;
  logic [1:0]           idx_q;
  logic [ByteWidth-1:0] cur_byte;
  logic                 load, take, is_last;

  always_comb begin
    case (idx_q)
      IdxFirst:  cur_byte = q_stat_i.head.byte0;
      IdxSecond: cur_byte = q_stat_i.head.byte1;
      IdxThird:  cur_byte = q_stat_i.head.byte2;
      default:   cur_byte = q_stat_i.head.byte0;
    endcase
  end

  assign load    = !valid_q || !out_stall_i;
  assign take    = load && !q_stat_i.empty;
  assign is_last = (idx_q + 2'd1) == q_stat_i.head.num_bytes;
  assign pop_o   = take && is_last;

  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_q    <= cur_byte;
      store_q   <= q_stat_i.head.store;
      summary_q <= q_stat_i.head.summary;
      length_q  <= q_stat_i.head.length;
      last_q    <= is_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= IdxFirst;
    end else begin
      if (load) begin
        valid_q <= !q_stat_i.empty;
      end
      if (take) begin
        idx_q <= is_last ? IdxFirst : idx_q + 2'd1;
      end
    end
  end

  assign out_valid_o      = valid_q;
  assign out_byte_o       = byte_q;
  assign store_byte_o     = store_q;
  assign is_summary_o     = summary_q;
  assign encoded_length_o = length_q;
  assign last_o           = last_q;

endmodule

`default_nettype wire

@@ hw/rtl/ucs2_to_utf8_stream_encoder.sv @@
// Top level of the UCS-2 to UTF-8 stream encoder.
//
//  channel | handshake               | payload
//  --------+-------------------------+----------------------------------------------
//  in      | in_valid_i / in_stall_o | code_unit_i, end_marker_i
//  out     | out_valid_o/out_stall_i | out_byte_o, store_byte_o, is_summary_o,
//          |                         | encoded_length_o, last_o
//  cfg     | cfg_valid_i/cfg_ready_o | cfg_buffer_size_i
//
//  A code unit yields 1 to 3 bytes; the output register moves one byte per cycle
//  while out_stall_i is low. A unit that does not fit is accepted but not queued.
//  Input is taken while the four-entry request queue has room.
//  Reset clears the running length, the queue and the output valid, and sets the
//  buffer size to 256. An output stall reaches the input only through a full queue.
`default_nettype none

module ucs2_to_utf8_stream_encoder
  import ucs2u8_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = 24
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CfgWidth-1:0]  cfg_buffer_size_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [UnitWidth-1:0] code_unit_i,
  input  wire logic                 end_marker_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [ByteWidth-1:0]      out_byte_o,
  output logic                      store_byte_o,
  output logic                      is_summary_o,
  output logic [CfgWidth-1:0]       encoded_length_o,
  output logic                      last_o
);

  push_t  push;
  qstat_t q_stat;
  logic   pop;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_stat.full;

  ucs2u8_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_buffer_size_i(cfg_buffer_size_i),
    .in_valid_i       (in_valid_i),
    .code_unit_i      (code_unit_i),
    .end_marker_i     (end_marker_i),
    .q_full_i         (q_stat.full),
    .push_o           (push)
  );

  ucs2u8_queue u_queue (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .pop_i (pop),
    .stat_o(q_stat)
  );

  ucs2u8_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_stat_i        (q_stat),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_byte_o      (out_byte_o),
    .store_byte_o    (store_byte_o),
    .is_summary_o    (is_summary_o),
    .encoded_length_o(encoded_length_o),
    .last_o          (last_o)
  );

  a_summary_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_summary_o |-> last_o)
    else $error("summary result without last");

  a_byte_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_summary_o |-> store_byte_o && (encoded_length_o == '0))
    else $error("byte result with bad store or length");

  a_end_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && end_marker_i |=> !q_stat.empty)
    else $error("end marker request not queued");

endmodule

`default_nettype wire
